### src/upsample_filter_interp_resampler_top_defines.svh
// Assertion macros for the upsampling resampler.
// Included by the top level; expects clk and arst_n in scope.
`ifndef UPSAMPLE_FILTER_INTERP_RESAMPLER_TOP_DEFINES_SVH
`define UPSAMPLE_FILTER_INTERP_RESAMPLER_TOP_DEFINES_SVH

// expression must never hold
`define RESMP_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

// antecedent implies consequent on the next cycle
`define RESMP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/resmp_pkg.sv
// Package for the upsampling resampler: formats, constants, sequencer states,
// MAC request types and feedback coefficient tables. No dependencies.
`default_nettype none
package resmp_pkg;
	localparam int FRAC_BITS  = 24;
	localparam int VAL_W      = 40;
	localparam int ACC_W      = 66;
	localparam int A_W        = VAL_W + 1;
	localparam int B_W        = 24;
	localparam int CHUNK_W    = 8;
	localparam int MAC_STEPS  = B_W / CHUNK_W;
	localparam int RING_DEPTH = 8;
	localparam int RING_AW    = $clog2(RING_DEPTH);
	localparam int PH_W       = 20;
	localparam int SMP_W      = 16;
	localparam int CFG_AW     = 2;
	localparam int CFG_DW     = 24;
	localparam int FB_SHIFT   = 20;
	localparam int OUT_SHIFT  = FRAC_BITS + 16 - 2;
	localparam logic [3:0]  MAX_OUT   = 4'd10;
	localparam logic [2:0]  LAST_PASS = 3'd5;
	localparam logic [PH_W-1:0] MIN_STEP  = 20'd32768;
	localparam logic [PH_W-1:0] PHASE_MAX = 20'hFFFFF;
	localparam logic [PH_W-1:0] PH_INC_RST = 20'd194783;
	localparam logic [B_W-1:0]  SCALE_RST  = 24'd65536;

	localparam logic [CFG_AW-1:0] REG_PHASE_INC   = 2'd0;
	localparam logic [CFG_AW-1:0] REG_INPUT_SCALE = 2'd1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCALE_GO, ST_SCALE_W, ST_FF, ST_FB_GO, ST_FB_W, ST_FB_END,
		ST_CHECK, ST_SEND, ST_RD_A, ST_INT_A_GO, ST_INT_A_W, ST_INT_B_GO,
		ST_INT_B_W, ST_INT_END
	} st_t;

	typedef struct packed {
		logic                  go;
		logic                  clr;
		logic signed [A_W-1:0] a;
		logic [B_W-1:0]        b;
	} mac_req_t;

	typedef struct packed {
		logic busy;
	} mac_sts_t;

	// magnitude of Q1.20 feedback coefficient
	function automatic logic [B_W-1:0] fb_mag(input logic [1:0] idx);
		logic [B_W-1:0] m;
		unique case (idx)
			2'd0: m = 24'd21655;
			2'd1: m = 24'd88325;
			2'd2: m = 24'd560255;
			default: m = 24'd409617;
		endcase
		return m;
	endfunction

	function automatic logic fb_neg(input logic [1:0] idx);
		return ~idx[0];
	endfunction
endpackage
`default_nettype wire

### src/upsample_filter_interp_resampler_top.sv
// Each input word is taken in idle and then runs through the filter passes;
// its output words follow, plus any wait on m_axis_tready.
// A new input word is taken only back in idle, after filtering and all outputs;
// this pace is set by the single 41x8 MAC that takes three passes per product.
// Reset clears filter history, ring indices, phase and the two registers to
// their defaults; ring contents are unwritten until filled.
`default_nettype none
`include "upsample_filter_interp_resampler_top_defines.svh"
module upsample_filter_interp_resampler_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic [15:0]                      s_axis_tdata, // [15:0] sample_in
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	output logic [15:0]                           m_axis_tdata, // [15:0] sample_out
	output logic                                  m_axis_tlast, // last_of_run
	input  wire logic                             cfg_we,
	input  wire logic [resmp_pkg::CFG_AW-1:0]     cfg_addr,
	input  wire logic [resmp_pkg::CFG_DW-1:0]     cfg_data
);
	import resmp_pkg::*;

	st_t state_q, state_d;
	mac_req_t mac_req;
	mac_sts_t mac_sts;
	logic signed [ACC_W-1:0] mac_acc;

	logic [PH_W-1:0] phase_inc_q;
	logic [B_W-1:0]  scale_q;
	logic signed [SMP_W-1:0] sample_q;
	logic [2:0] fi_q;
	logic [1:0] fb_q;
	logic [3:0] n_q;
	logic pend_q, brk_q;
	logic signed [VAL_W-1:0] xh1_q [4];
	logic signed [VAL_W-1:0] yh1_q [4];
	logic signed [VAL_W-1:0] xh2_q [4];
	logic signed [VAL_W-1:0] yh2_q [4];
	logic signed [VAL_W-1:0] x_q, ylast_q;
	logic signed [VAL_W+3:0] ff_q;
	logic [RING_AW-1:0] wr_q, rd_q;
	logic [PH_W-1:0] phase_q;
	logic signed [VAL_W-1:0] ring [RING_DEPTH];
	logic signed [VAL_W-1:0] rdata_q;
	logic [RING_AW-1:0] raddr;
	logic [SMP_W-1:0] out_data_q;
	logic out_last_q, out_valid_q;

	logic stage_two;
	logic signed [VAL_W-1:0] raw, x_new, y_new;
	logic [VAL_W-1:0] raw_mag, r_mag;
	logic [64:0] r_wide;
	logic signed [VAL_W-1:0] xs [4];
	logic signed [VAL_W-1:0] ys [4];
	logic signed [VAL_W+3:0] ff_new;
	logic signed [ACC_W-1:0] fb_t;
	logic signed [VAL_W+7:0] y_sum;
	logic signed [A_W-1:0] y_ext;
	logic [PH_W-1:0] step;
	logic [PH_W:0] ph_sum;
	logic [PH_W-1:0] ph_adv;
	logic [16:0] w0;
	logic [ACC_W-1:0] acc_mag;
	logic [ACC_W-OUT_SHIFT-1:0] m_val;
	logic [SMP_W-1:0] out_conv;
	logic [3:0] whole;
	logic [RING_AW-1:0] fill, fill2;
	logic brk_c;
	logic [RING_AW-1:0] rd_c;
	logic [PH_W-1:0] phase_c;

	resmp_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.sts    (mac_sts),
		.acc    (mac_acc)
	);

	// filter datapath
	always_comb begin
		stage_two = !(fi_q == 3'd0 || fi_q == 3'd3);
		if (fi_q == 3'd0) begin
			raw = $signed({sample_q, {FRAC_BITS{1'b0}}});
		end else if (fi_q == 3'd1 || fi_q == 3'd4) begin
			raw = ylast_q;
		end else begin
			raw = '0;
		end
		raw_mag = raw[VAL_W-1] ? VAL_W'(-raw) : VAL_W'(raw);
		r_wide = {1'b0, mac_acc[63:0]} + 65'(1 << (FRAC_BITS - 1));
		r_mag = r_wide[FRAC_BITS +: VAL_W];
		x_new = raw[VAL_W-1] ? -$signed(r_mag) : $signed(r_mag);
		for (int i = 0; i < 4; i++) begin
			xs[i] = stage_two ? xh2_q[i] : xh1_q[i];
			ys[i] = stage_two ? yh2_q[i] : yh1_q[i];
		end
		ff_new = (VAL_W+4)'(xs[0]) + (VAL_W+4)'(x_q)
			+ (((VAL_W+4)'(xs[1]) + (VAL_W+4)'(xs[3])) <<< 2)
			+ (VAL_W+4)'(xs[2]) * $signed(5'sd6);
		y_ext = A_W'(ys[fb_q]);
		fb_t = (mac_acc + ACC_W'(1 << (FB_SHIFT - 1))) >>> FB_SHIFT;
		y_sum = (VAL_W+8)'(ff_q) + (VAL_W+8)'(fb_t);
		if (y_sum > (VAL_W+8)'(49'sh7FFFFFFFFF)) begin
			y_new = {1'b0, {(VAL_W-1){1'b1}}};
		end else if (y_sum < -(VAL_W+8)'(49'sh8000000000)) begin
			y_new = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			y_new = y_sum[VAL_W-1:0];
		end
	end

	// interpolation and phase datapath
	always_comb begin
		step = (phase_inc_q < MIN_STEP) ? MIN_STEP : phase_inc_q;
		ph_sum = {1'b0, phase_q} + {1'b0, step};
		ph_adv = ph_sum[PH_W] ? PHASE_MAX : ph_sum[PH_W-1:0];
		w0 = 17'h10000 - {1'b0, phase_q[15:0]};
		acc_mag = mac_acc[ACC_W-1] ? ACC_W'(-mac_acc) : ACC_W'(mac_acc);
		m_val = acc_mag[ACC_W-1:OUT_SHIFT];
		if (mac_acc[ACC_W-1]) begin
			out_conv = (m_val > 28'd32768) ? 16'h8000 : 16'(-m_val);
		end else begin
			out_conv = (m_val > 28'd32767) ? 16'h7FFF : m_val[SMP_W-1:0];
		end
		whole = phase_q[PH_W-1:16];
		fill = wr_q - rd_q;
		fill2 = fill - whole[RING_AW-1:0];
		rd_c = rd_q;
		phase_c = phase_q;
		if (n_q == MAX_OUT) begin
			brk_c = 1'b1;
		end else if (whole != 4'd0 && {1'b0, fill} < whole) begin
			rd_c = rd_q + fill;
			phase_c = phase_q - {1'b0, fill, 16'h0000};
			brk_c = 1'b1;
		end else begin
			rd_c = rd_q + whole[RING_AW-1:0];
			phase_c = phase_q - {whole, 16'h0000};
			brk_c = fill2 < 3'd2;
		end
		raddr = (state_q == ST_RD_A) ? rd_q : rd_q + 3'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mac_req = '0;
		s_axis_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = ST_SCALE_GO;
				end
			end
			ST_SCALE_GO: begin
				mac_req.go = 1'b1;
				mac_req.clr = 1'b1;
				mac_req.a = $signed({1'b0, raw_mag});
				mac_req.b = scale_q;
				state_d = ST_SCALE_W;
			end
			ST_SCALE_W: if (!mac_sts.busy) state_d = ST_FF;
			ST_FF: state_d = ST_FB_GO;
			ST_FB_GO: begin
				mac_req.go = 1'b1;
				mac_req.clr = (fb_q == 2'd0);
				mac_req.a = fb_neg(fb_q) ? -y_ext : y_ext;
				mac_req.b = fb_mag(fb_q);
				state_d = ST_FB_W;
			end
			ST_FB_W: begin
				if (!mac_sts.busy) begin
					state_d = (fb_q == 2'd3) ? ST_FB_END : ST_FB_GO;
				end
			end
			ST_FB_END: state_d = (fi_q == LAST_PASS) ? ST_CHECK : ST_SCALE_GO;
			ST_CHECK: begin
				if (pend_q) begin
					state_d = ST_SEND;
				end else begin
					state_d = brk_c ? ST_IDLE : ST_RD_A;
				end
			end
			ST_SEND: begin
				if (m_axis_tready) begin
					state_d = brk_q ? ST_IDLE : ST_RD_A;
				end
			end
			ST_RD_A: state_d = ST_INT_A_GO;
			ST_INT_A_GO: begin
				mac_req.go = 1'b1;
				mac_req.clr = 1'b1;
				mac_req.a = A_W'(rdata_q);
				mac_req.b = B_W'(w0);
				state_d = ST_INT_A_W;
			end
			ST_INT_A_W: if (!mac_sts.busy) state_d = ST_INT_B_GO;
			ST_INT_B_GO: begin
				mac_req.go = 1'b1;
				mac_req.a = A_W'(rdata_q);
				mac_req.b = B_W'(phase_q[15:0]);
				state_d = ST_INT_B_W;
			end
			ST_INT_B_W: if (!mac_sts.busy) state_d = ST_INT_END;
			ST_INT_END: state_d = ST_CHECK;
			default: state_d = ST_IDLE;
		endcase
	end

	// control and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_inc_q <= PH_INC_RST;
			scale_q <= SCALE_RST;
			fi_q <= '0;
			fb_q <= '0;
			n_q <= '0;
			pend_q <= 1'b0;
			brk_q <= 1'b0;
			wr_q <= '0;
			rd_q <= '0;
			phase_q <= '0;
			out_valid_q <= 1'b0;
			ylast_q <= '0;
			for (int i = 0; i < 4; i++) begin
				xh1_q[i] <= '0;
				yh1_q[i] <= '0;
				xh2_q[i] <= '0;
				yh2_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_addr == REG_PHASE_INC) begin
					phase_inc_q <= cfg_data[PH_W-1:0];
				end else if (cfg_addr == REG_INPUT_SCALE) begin
					scale_q <= cfg_data;
				end
			end
			unique case (state_q)
				ST_IDLE: fi_q <= '0;
				ST_FF: fb_q <= '0;
				ST_FB_W: if (!mac_sts.busy && fb_q != 2'd3) fb_q <= fb_q + 2'd1;
				ST_FB_END: begin
					if (stage_two) begin
						for (int i = 0; i < 3; i++) begin
							xh2_q[i] <= xh2_q[i+1];
							yh2_q[i] <= yh2_q[i+1];
						end
						xh2_q[3] <= x_q;
						yh2_q[3] <= y_new;
						wr_q <= wr_q + 3'd1;
					end else begin
						for (int i = 0; i < 3; i++) begin
							xh1_q[i] <= xh1_q[i+1];
							yh1_q[i] <= yh1_q[i+1];
						end
						xh1_q[3] <= x_q;
						yh1_q[3] <= y_new;
						ylast_q <= y_new;
					end
					fi_q <= fi_q + 3'd1;
					n_q <= '0;
					pend_q <= 1'b0;
				end
				ST_CHECK: begin
					rd_q <= rd_c;
					phase_q <= phase_c;
					brk_q <= brk_c;
					if (pend_q) out_valid_q <= 1'b1;
				end
				ST_SEND: begin
					if (m_axis_tready) begin
						out_valid_q <= 1'b0;
						pend_q <= 1'b0;
					end
				end
				ST_INT_END: begin
					pend_q <= 1'b1;
					phase_q <= ph_adv;
					n_q <= n_q + 4'd1;
				end
				default: ;
			endcase
		end
	end

	// payload registers and ring
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) sample_q <= s_axis_tdata;
		if (state_q == ST_SCALE_W && !mac_sts.busy) x_q <= x_new;
		if (state_q == ST_FF) ff_q <= ff_new;
		if (state_q == ST_CHECK && pend_q) out_last_q <= brk_c;
		if (state_q == ST_INT_END) out_data_q <= out_conv;
		if (state_q == ST_FB_END && stage_two) ring[wr_q] <= y_new;
		rdata_q <= ring[raddr];
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tlast = out_last_q;

	`RESMP_ASSERT_NEVER(a_busy_io, s_axis_tready && m_axis_tvalid, "input taken while word pending")
	`RESMP_ASSERT_NEVER(a_mac_idle, s_axis_tready && mac_sts.busy, "MAC busy while idle")
	`RESMP_ASSERT_NEVER(a_out_cnt, n_q > MAX_OUT, "too many outputs for one input")
	`RESMP_ASSERT_NEXT(a_last_idle, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready, "not idle after last word")
endmodule
`default_nettype wire

### src/resmp_mac.sv
// Shared multiply-accumulate unit: signed 41-bit by unsigned 24-bit,
// eight multiplier bits per cycle. Depends on resmp_pkg.
`default_nettype none
module resmp_mac (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire resmp_pkg::mac_req_t               req,
	output resmp_pkg::mac_sts_t                    sts,
	output logic signed [resmp_pkg::ACC_W-1:0]     acc
);
	import resmp_pkg::*;

	logic                  busy_q;
	logic [1:0]            cnt_q;
	logic signed [A_W-1:0] a_q;
	logic [B_W-1:0]        b_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [A_W+CHUNK_W:0] prod;
	logic signed [ACC_W-1:0] term;

	assign prod = a_q * $signed({1'b0, b_q[CHUNK_W-1:0]});
	assign term = ACC_W'(prod) <<< {cnt_q, 3'b000};
	assign sts.busy = busy_q;
	assign acc = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			acc_q  <= '0;
		end else if (req.go) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			if (req.clr) begin
				acc_q <= '0;
			end
		end else if (busy_q) begin
			acc_q <= acc_q + term;
			cnt_q <= cnt_q + 2'd1;
			if (cnt_q == 2'(MAC_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			a_q <= req.a;
			b_q <= req.b;
		end else if (busy_q) begin
			b_q <= b_q >> CHUNK_W;
		end
	end
endmodule
`default_nettype wire
